>>> hw/rtl/wrms_pkg.sv
// constants and sequencer state type for the windowed rms meter
package wrms_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int MAX_WINDOW  = 64;
  localparam int WIN_W       = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(30);

  localparam int SUM_W  = 2 * SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int WK_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int ALU_W  = REM_W + 2;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_DONE = 5'b10000
  } wrms_state_t;

endpackage

>>> hw/rtl/windowed_rms_meter.sv
// windowed rms meter: square accumulator, shared subtract unit for divide and square root
// usage:
//   in channel (in_valid/in_ready/in_sample) takes one converter sample per word.
//   out channel (out_valid/out_ready/out_rms_value) gives one word per closed window:
//   floor(sqrt(floor(sum of squares / window))).
//   cfg_wr_en/cfg_wr_data write the window length (0 acts as 1, above 64 acts as 64);
//   write it only while the block is idle.
// sequence:
//   a sample that does not close a window passes through accept and accumulate.
//   a closing sample is accepted and accumulated, then worked out bit by bit:
//   one restoring divide bit per cycle, then one root bit per cycle, both on the
//   same compare/subtract unit, then a load of the output register.
//   in_ready is low for the whole of that sequence.
// reset:
//   window length returns to 30, sum and sample count clear, out_valid drops.
// stall:
//   the result sits in the output register while accumulation of the next window
//   goes on; a further finished window waits until that register is taken.
module windowed_rms_meter
  import wrms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_rms_value,
  input  logic                   cfg_wr_en,
  input  logic [WIN_W-1:0]       cfg_wr_data
);

  wrms_state_t            state_r, state_nxt;
  logic [WIN_W-1:0]       win_r;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [WIN_W-1:0]       count_r, count_nxt;
  logic [WIN_W-1:0]       div_r, div_nxt;
  logic [WK_W-1:0]        wk_r, wk_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [ROOT_W-1:0]      root_r, root_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic [WIN_W-1:0]         win_eff;
  logic [2*SAMPLE_BITS-1:0] square;
  logic [SUM_W-1:0]         sum_acc;
  logic [WIN_W-1:0]         cnt_inc;
  logic [ALU_W-1:0]         alu_a, alu_b;
  logic [ALU_W:0]           alu_diff;
  logic                     alu_ge;

  // effective window length
  always_comb begin
    priority if (win_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_r > WIN_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = win_r;
    end
  end

  assign square  = sample_r * sample_r;
  assign sum_acc = sum_r + SUM_W'(square);
  assign cnt_inc = count_r + WIN_W'(1);

  // shared compare/subtract unit
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = ~alu_diff[ALU_W];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_DIV: begin
        alu_a = ALU_W'({rem_r[WIN_W-1:0], wk_r[SUM_W-1]});
        alu_b = ALU_W'(div_r);
      end
      S_SQRT: begin
        alu_a = ALU_W'({rem_r, wk_r[WK_W-1:WK_W-2]});
        alu_b = ALU_W'({root_r, 2'b01});
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    div_nxt       = div_r;
    wk_nxt        = wk_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        if ((cnt_inc >= win_eff) || (cnt_inc == '0)) begin
          wk_nxt    = WK_W'(sum_acc);
          sum_nxt   = '0;
          count_nxt = '0;
          div_nxt   = win_eff;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          sum_nxt   = sum_acc;
          count_nxt = cnt_inc;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        rem_nxt  = alu_ge ? REM_W'(alu_diff[WIN_W-1:0]) : REM_W'(alu_a[WIN_W-1:0]);
        wk_nxt   = WK_W'({wk_r[SUM_W-2:0], alu_ge});
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle
        rem_nxt  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], alu_ge};
        wk_nxt   = {wk_r[WK_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = root_r[SAMPLE_BITS-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WIN_RESET;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    div_r      <= div_nxt;
    wk_r       <= wk_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_rms_value = out_data_r;

`ifndef SYNTHESIS
  // divide remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < REM_W'(div_r)))
    else $error("divide remainder out of range");

  // root remainder never exceeds twice the partial root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (rem_r <= REM_W'({root_r, 1'b0})))
    else $error("root remainder out of range");

  // an open window never holds a full maximum window of samples
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r < WIN_W'(MAX_WINDOW)))
    else $error("sample count out of range");

  // a finished root is only loaded into a free or draining output register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result overwrote a pending word");
`endif

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the windowed rms meter
`timescale 1ns / 1ps

import wrms_pkg::*;

class rms_scoreboard;
  bit [WIN_W-1:0]       window_reg;
  bit [33:0]            square_sum;
  bit [WIN_W-1:0]       sample_count;
  bit [SAMPLE_BITS-1:0] expected_rms[$];
  int unsigned          errors;

  function new();
    window_reg   = WIN_RESET;
    square_sum   = '0;
    sample_count = '0;
    errors       = 0;
  endfunction

  function void write_window(bit [WIN_W-1:0] value);
    window_reg = value;
  endfunction

  function bit [33:0] floor_sqrt(bit [33:0] value);
    bit [33:0] root;
    bit [33:0] probe;
    bit [33:0] rest;
    root  = '0;
    rest  = value;
    probe = 34'd1 << 32;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function void note_sample(bit [SAMPLE_BITS-1:0] sample);
    bit [WIN_W-1:0] eff;
    bit [33:0]      mean;
    if (window_reg == 0) eff = WIN_W'(1);
    else if (window_reg > MAX_WINDOW) eff = WIN_W'(MAX_WINDOW);
    else eff = window_reg;
    square_sum   = square_sum + 34'(sample) * 34'(sample);
    sample_count = sample_count + 1'b1;
    if (sample_count >= eff || sample_count == 0) begin
      mean = square_sum / 34'(eff);
      expected_rms.push_back(SAMPLE_BITS'(floor_sqrt(mean)));
      square_sum   = '0;
      sample_count = '0;
    end
  endfunction

  function void check_rms(bit [SAMPLE_BITS-1:0] got);
    bit [SAMPLE_BITS-1:0] want;
    if (expected_rms.size() == 0) begin
      $display("%0t: unexpected rms word, expected none, actual %0d", $time, got);
      errors++;
    end else begin
      want = expected_rms.pop_front();
      if (want !== got) begin
        $display("%0t: rms mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_rms.size();
  endfunction
endclass

module tb_top;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_WORDS  = 1400;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [SAMPLE_BITS-1:0] out_rms_value;
  logic                   cfg_wr_en;
  logic [WIN_W-1:0]       cfg_wr_data;

  rms_scoreboard sb = new();
  int unsigned   stall_cycles;
  int unsigned   words_sent;
  logic          hold_req;
  bit            held;

  windowed_rms_meter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rms_value(out_rms_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.write_window(cfg_wr_data);
      if (in_valid && in_ready) sb.note_sample(in_sample);
      if (out_valid && out_ready) sb.check_rms(out_rms_value);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    stall_cycles = 0;
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(12, 60);
    if (r < 50) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int unsigned style);
    case (style)
      0: return SAMPLE_BITS'($urandom_range(0, 1023));
      1: return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      2: return SAMPLE_BITS'($urandom_range(0, 31));
      default: return SAMPLE_BITS'($urandom_range(960, 1023));
    endcase
  endfunction

  // receiver: ready runs and stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned run_len;
    int unsigned stall_len;
    out_ready <= 1'b0;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 4);
      stall_len = pick_gap();
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_len != 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [SAMPLE_BITS-1:0] value, input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [WIN_W-1:0] win;
    int unsigned      eff;
    int unsigned      count;
    int unsigned      style;
    bit               burst;
    int unsigned      phase;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_sample   <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    hold_req    <= 1'b0;
    words_sent  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window length, one block and part of the next
    repeat (33) offer(pick_sample(0), 1'b0);
    settle();

    // single-sample windows, extremes of the sample
    write_window(7'd1);
    offer(10'd0, 1'b0);
    offer(10'd1023, 1'b0);
    offer(10'd1, 1'b0);
    offer(10'd512, 1'b0);
    settle();
    // zero window acts as one
    write_window(7'd0);
    offer(10'd1023, 1'b0);
    offer(10'd0, 1'b0);
    settle();
    write_window(7'd2);
    offer(10'd1023, 1'b1);
    offer(10'd1023, 1'b0);
    settle();
    // shrink the window below the running count mid-block
    write_window(7'd4);
    repeat (3) offer(10'd1023, 1'b0);
    settle();
    write_window(7'd2);
    offer(10'd1023, 1'b0);
    settle();

    // long receiver hold-off with small windows so the block backs up
    write_window(7'd1);
    hold_req <= 1'b1;
    repeat (40) offer(pick_sample(0), 1'b1);
    settle();

    words_sent = 0;
    phase      = 0;
    while (words_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0: win = 7'd0;
        1: win = 7'd1;
        2: win = 7'd64;
        3: win = 7'd127;
        4: win = 7'd65;
        5, 6: win = WIN_W'($urandom_range(0, 127));
        default: win = WIN_W'($urandom_range(1, 12));
      endcase
      eff   = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;
      count = $urandom_range(1, 3 * eff + 2);
      burst = ($urandom_range(0, 3) == 0);
      style = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
      write_window(win);
      repeat (count) begin
        offer(pick_sample(($urandom_range(0, 4) == 0) ? 0 : style), burst);
      end
      // every fifth phase the sender first idles a while; every phase then drains completely
      phase++;
      if (phase % 5 == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
      settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
